/* src/ipfk_pkg.sv */
// ----------------------------------------------------------------------------
// ipfk_pkg
// Types and constants shared by the flow key extractor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ipfk_pkg;

  typedef enum logic [1:0] {
    FAM_NONE = 2'd0,
    FAM_IPV4 = 2'd1,
    FAM_IPV6 = 2'd2
  } family_e;

  localparam logic [3:0] VER_IPV4 = 4'd4;
  localparam logic [3:0] VER_IPV6 = 4'd6;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam int IPV4_MIN_HDR  = 20;
  localparam int IPV4_MAX_HDR  = 60;
  localparam int IPV6_HDR_LEN  = 40;
  localparam int PORT_BYTES    = 4;

  // ipv4 header byte offsets
  localparam int V4_PROTO_OFS  = 9;
  localparam int V4_SRC_OFS    = 12;
  localparam int V4_DST_OFS    = 16;
  localparam int V4_ADDR_BYTES = 4;

  // ipv6 header byte offsets
  localparam int V6_PROTO_OFS  = 6;
  localparam int V6_SRC_OFS    = 8;
  localparam int V6_DST_OFS    = 24;
  localparam int V6_WORD_BYTES = 8;

  // captured packet state as it stands after the current byte
  typedef struct packed {
    logic [7:0]  version;
    logic [7:0]  proto;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] tgt_hi;
    logic [63:0] tgt_lo;
    logic [15:0] src_port;
    logic [15:0] tgt_port;
    logic        len_ge_v4min;
    logic        len_ge_v6hdr;
    logic        len_ge_ihl;
    logic        len_ge_ihl_ports;
    logic        len_ge_v6_ports;
  } pkt_view_t;

  typedef struct packed {
    family_e     family;
    logic [7:0]  protocol;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] tgt_hi;
    logic [63:0] tgt_lo;
    logic [15:0] src_port;
    logic [15:0] tgt_port;
  } flow_key_t;

endpackage

`default_nettype wire

/* src/ipfk_if.sv */
// ----------------------------------------------------------------------------
// ipfk_if
// Valid/ready channels for packet bytes in and flow keys out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipfk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
  modport monitor (input valid, input data_byte, input last_byte, input ready);
endinterface

interface ipfk_key_if;
  logic        valid;
  logic        ready;
  logic [1:0]  family_code;
  logic [7:0]  protocol_number;
  logic [63:0] source_high;
  logic [63:0] source_low;
  logic [63:0] target_high;
  logic [63:0] target_low;
  logic [15:0] source_port_num;
  logic [15:0] target_port_num;

  modport source (
    output valid, output family_code, output protocol_number,
    output source_high, output source_low, output target_high, output target_low,
    output source_port_num, output target_port_num, input ready
  );
  modport sink (
    input valid, input family_code, input protocol_number,
    input source_high, input source_low, input target_high, input target_low,
    input source_port_num, input target_port_num, output ready
  );
  modport monitor (
    input valid, input family_code, input protocol_number,
    input source_high, input source_low, input target_high, input target_low,
    input source_port_num, input target_port_num, input ready
  );
endinterface

`default_nettype wire

/* src/ipfk_capture.sv */
// ----------------------------------------------------------------------------
// ipfk_capture
// Per-packet byte counter and header field capture registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfk_capture #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              last_i,
  output ipfk_pkg::pkt_view_t    view_o
);
  import ipfk_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] idx_q, len;
  logic [7:0]  version_q, version_d;
  logic [7:0]  proto_q, proto_d;
  logic [63:0] src_hi_q, src_hi_d, src_lo_q, src_lo_d;
  logic [63:0] tgt_hi_q, tgt_hi_d, tgt_lo_q, tgt_lo_d;
  logic [31:0] ports_q, ports_d;
  logic [5:0]  ihl_q, ihl_d;
  logic [3:0]  ver_q;

  assign ver_q = version_q[7:4];
  assign ihl_q = {version_q[3:0], 2'b00};
  assign ihl_d = {version_d[3:0], 2'b00};
  assign len   = (idx_q == CntMax) ? CntMax : idx_q + 1'b1;

  always_comb begin
    version_d = version_q;
    proto_d   = proto_q;
    src_hi_d  = src_hi_q;
    src_lo_d  = src_lo_q;
    tgt_hi_d  = tgt_hi_q;
    tgt_lo_d  = tgt_lo_q;
    ports_d   = ports_q;
    if (idx_q == '0) begin
      version_d = byte_i;
    end else if (ver_q == VER_IPV4) begin
      if (idx_q == COUNT_WIDTH'(V4_PROTO_OFS)) proto_d = byte_i;
      for (int k = 0; k < V4_ADDR_BYTES; k++) begin
        if (idx_q == COUNT_WIDTH'(V4_SRC_OFS + k)) src_hi_d[63-8*k -: 8] = byte_i;
        if (idx_q == COUNT_WIDTH'(V4_DST_OFS + k)) tgt_hi_d[63-8*k -: 8] = byte_i;
      end
      if (ihl_q >= 6'(IPV4_MIN_HDR)) begin
        for (int r = 0; r < PORT_BYTES; r++) begin
          if (idx_q == COUNT_WIDTH'(ihl_q) + COUNT_WIDTH'(r)) ports_d[31-8*r -: 8] = byte_i;
        end
      end
    end else if (ver_q == VER_IPV6) begin
      if (idx_q == COUNT_WIDTH'(V6_PROTO_OFS)) proto_d = byte_i;
      for (int k = 0; k < V6_WORD_BYTES; k++) begin
        if (idx_q == COUNT_WIDTH'(V6_SRC_OFS + k)) src_hi_d[63-8*k -: 8] = byte_i;
        if (idx_q == COUNT_WIDTH'(V6_SRC_OFS + V6_WORD_BYTES + k)) begin
          src_lo_d[63-8*k -: 8] = byte_i;
        end
        if (idx_q == COUNT_WIDTH'(V6_DST_OFS + k)) tgt_hi_d[63-8*k -: 8] = byte_i;
        if (idx_q == COUNT_WIDTH'(V6_DST_OFS + V6_WORD_BYTES + k)) begin
          tgt_lo_d[63-8*k -: 8] = byte_i;
        end
      end
      for (int r = 0; r < PORT_BYTES; r++) begin
        if (idx_q == COUNT_WIDTH'(IPV6_HDR_LEN + r)) ports_d[31-8*r -: 8] = byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      version_q <= '0;
      proto_q   <= '0;
      src_hi_q  <= '0;
      src_lo_q  <= '0;
      tgt_hi_q  <= '0;
      tgt_lo_q  <= '0;
      ports_q   <= '0;
    end else if (step_i) begin
      if (last_i) begin
        idx_q     <= '0;
        version_q <= '0;
        proto_q   <= '0;
        src_hi_q  <= '0;
        src_lo_q  <= '0;
        tgt_hi_q  <= '0;
        tgt_lo_q  <= '0;
        ports_q   <= '0;
      end else begin
        idx_q     <= len;
        version_q <= version_d;
        proto_q   <= proto_d;
        src_hi_q  <= src_hi_d;
        src_lo_q  <= src_lo_d;
        tgt_hi_q  <= tgt_hi_d;
        tgt_lo_q  <= tgt_lo_d;
        ports_q   <= ports_d;
      end
    end
  end

  always_comb begin
    view_o.version          = version_d;
    view_o.proto            = proto_d;
    view_o.src_hi           = src_hi_d;
    view_o.src_lo           = src_lo_d;
    view_o.tgt_hi           = tgt_hi_d;
    view_o.tgt_lo           = tgt_lo_d;
    view_o.src_port         = ports_d[31:16];
    view_o.tgt_port         = ports_d[15:0];
    view_o.len_ge_v4min     = len >= COUNT_WIDTH'(IPV4_MIN_HDR);
    view_o.len_ge_v6hdr     = len >= COUNT_WIDTH'(IPV6_HDR_LEN);
    view_o.len_ge_ihl       = len >= COUNT_WIDTH'(ihl_d);
    view_o.len_ge_ihl_ports = len >= COUNT_WIDTH'({1'b0, ihl_d} + 7'(PORT_BYTES));
    view_o.len_ge_v6_ports  = len >= COUNT_WIDTH'(IPV6_HDR_LEN + PORT_BYTES);
  end

endmodule

`default_nettype wire

/* src/ipfk_keygen.sv */
// ----------------------------------------------------------------------------
// ipfk_keygen
// Family and port decision at the last byte, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfk_keygen (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  ipfk_pkg::pkt_view_t       view_i,
  input  wire logic                 ready_i,
  output logic                      valid_o,
  output ipfk_pkg::flow_key_t       key_o
);
  import ipfk_pkg::*;

  logic      valid_q;
  flow_key_t key_q, key_d;
  logic [3:0] ver;
  logic [5:0] ihl;
  logic       ihl_ok, ports_ok;
  family_e    fam;

  assign ver    = view_i.version[7:4];
  assign ihl    = {view_i.version[3:0], 2'b00};
  assign ihl_ok = (ihl >= 6'(IPV4_MIN_HDR)) && (ihl <= 6'(IPV4_MAX_HDR));

  always_comb begin
    fam = FAM_NONE;
    if (view_i.len_ge_v4min) begin
      if (ver == VER_IPV4 && ihl_ok && view_i.len_ge_ihl) begin
        fam = FAM_IPV4;
      end else if (ver == VER_IPV6 && view_i.len_ge_v6hdr) begin
        fam = FAM_IPV6;
      end
    end
    ports_ok = (view_i.proto == PROTO_TCP || view_i.proto == PROTO_UDP) &&
               ((fam == FAM_IPV4 && view_i.len_ge_ihl_ports) ||
                (fam == FAM_IPV6 && view_i.len_ge_v6_ports));

    key_d = '0;
    if (fam != FAM_NONE) begin
      key_d.family   = fam;
      key_d.protocol = view_i.proto;
      key_d.src_hi   = view_i.src_hi;
      key_d.tgt_hi   = view_i.tgt_hi;
      if (fam == FAM_IPV6) begin
        key_d.src_lo = view_i.src_lo;
        key_d.tgt_lo = view_i.tgt_lo;
      end
      if (ports_ok) begin
        key_d.src_port = view_i.src_port;
        key_d.tgt_port = view_i.tgt_port;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;

endmodule

`default_nettype wire

/* src/ip_flow_key_extractor_core.sv */
// ----------------------------------------------------------------------------
// ip_flow_key_extractor_core
// Builds an IPv4/IPv6 five-tuple flow key from a packet byte stream.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle, starting at the network header, and emits
// one flow key after the byte flagged last. An accepted byte is held in the
// input register, then updates the header capture registers; a last byte
// loads the key into the result register, which drives the key output.
// Sustained rate is one byte per cycle while the key sink keeps up; a key
// left waiting stalls the stream only when the next last byte reaches the
// input register. COUNT_WIDTH sets the saturating byte counter (7 to 32
// bits).
`default_nettype none

module ip_flow_key_extractor_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ipfk_byte_if.sink   byte_i,
  ipfk_key_if.source  key_o
);
  import ipfk_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance, load, key_valid;
  pkt_view_t  view;
  flow_key_t  key;

  assign advance      = in_vld_q && (!in_last_q || !key_valid || key_o.ready);
  assign load         = advance && in_last_q;
  assign byte_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
      in_last_q <= byte_i.last_byte;
    end
  end

  ipfk_capture #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .view_o (view)
  );

  ipfk_keygen u_keygen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .view_i  (view),
    .ready_i (key_o.ready),
    .valid_o (key_valid),
    .key_o   (key)
  );

  assign key_o.valid           = key_valid;
  assign key_o.family_code     = key.family;
  assign key_o.protocol_number = key.protocol;
  assign key_o.source_high     = key.src_hi;
  assign key_o.source_low      = key.src_lo;
  assign key_o.target_high     = key.tgt_hi;
  assign key_o.target_low      = key.tgt_lo;
  assign key_o.source_port_num = key.src_port;
  assign key_o.target_port_num = key.tgt_port;

endmodule

`default_nettype wire

/* src/ipfk_checker.sv */
// ----------------------------------------------------------------------------
// ipfk_checker
// Port-level checks on the flow key output, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfk_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        key_valid_i,
  input wire logic        key_ready_i,
  input wire logic [1:0]  family_i,
  input wire logic [7:0]  protocol_i,
  input wire logic [63:0] src_hi_i,
  input wire logic [63:0] src_lo_i,
  input wire logic [63:0] tgt_hi_i,
  input wire logic [63:0] tgt_lo_i,
  input wire logic [15:0] src_port_i,
  input wire logic [15:0] tgt_port_i
);
  import ipfk_pkg::*;

  // a stalled item holds
  a_key_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_i && !key_ready_i |=>
      key_valid_i && $stable(family_i) && $stable(protocol_i) &&
      $stable(src_hi_i) && $stable(tgt_hi_i) &&
      $stable(src_port_i) && $stable(tgt_port_i))
    else $error("key changed while stalled");

  a_family_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_i |-> (family_i == FAM_NONE || family_i == FAM_IPV4 ||
                     family_i == FAM_IPV6))
    else $error("bad family code");

  a_unparsed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_i && family_i == FAM_NONE |->
      protocol_i == '0 && src_hi_i == '0 &&
      tgt_hi_i == '0 && src_port_i == '0 &&
      tgt_port_i == '0)
    else $error("unparsed key not zero");

  a_v4_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_i && family_i != FAM_IPV6 |->
      src_lo_i == '0 && tgt_lo_i == '0)
    else $error("low address words set without ipv6");

  a_ports_proto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_i && (src_port_i != '0 || tgt_port_i != '0) |->
      protocol_i == PROTO_TCP || protocol_i == PROTO_UDP)
    else $error("ports set for non tcp/udp item");

endmodule

bind ip_flow_key_extractor_core ipfk_checker u_ipfk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .key_valid_i (key_o.valid),
  .key_ready_i (key_o.ready),
  .family_i    (key_o.family_code),
  .protocol_i  (key_o.protocol_number),
  .src_hi_i    (key_o.source_high),
  .src_lo_i    (key_o.source_low),
  .tgt_hi_i    (key_o.target_high),
  .tgt_lo_i    (key_o.target_low),
  .src_port_i  (key_o.source_port_num),
  .tgt_port_i  (key_o.target_port_num)
);

`default_nettype wire

/* dv/ip_flow_key_extractor_core_test.sv */
// ----------------------------------------------------------------------------
// ip_flow_key_extractor_core_test
// Streams IPv4, IPv6 and malformed packets byte by byte into the core with
// random gaps on both channels. A scoreboard rebuilds each flow key from the
// accepted bytes and compares every emitted key field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ip_flow_key_extractor_core_test;
  import ipfk_pkg::*;

  // narrow counter so that long packets reach saturation
  localparam int          CW      = 7;
  localparam int unsigned CNT_MAX = (1 << CW) - 1;

  class key_scoreboard;
    int unsigned count;
    logic [7:0]  ver_b;
    logic [7:0]  proto_b;
    logic [63:0] src_w[2];
    logic [63:0] tgt_w[2];
    logic [15:0] port_w[2];
    flow_key_t   keys_due[$];
    int          failures;

    function new();
      clear_packet();
      failures = 0;
    endfunction

    function void clear_packet();
      count   = 0;
      ver_b   = '0;
      proto_b = '0;
      src_w   = '{default: '0};
      tgt_w   = '{default: '0};
      port_w  = '{default: '0};
    endfunction

    function logic [63:0] place_byte(logic [63:0] w, int unsigned pos, logic [7:0] b);
      w[8 * (7 - pos) +: 8] = b;
      return w;
    endfunction

    function void place_port(int unsigned rel, logic [7:0] b);
      port_w[rel / 2][8 * (1 - rel % 2) +: 8] = b;
    endfunction

    function void capture_header(int unsigned idx, logic [7:0] b);
      int unsigned ihl_b;
      if (idx == 0) begin
        ver_b = b;
        return;
      end
      if (ver_b[7:4] == VER_IPV4) begin
        ihl_b = 4 * ver_b[3:0];
        if (idx == V4_PROTO_OFS) begin
          proto_b = b;
        end else if (idx >= V4_SRC_OFS && idx < V4_SRC_OFS + V4_ADDR_BYTES) begin
          src_w[0] = place_byte(src_w[0], idx - V4_SRC_OFS, b);
        end else if (idx >= V4_DST_OFS && idx < V4_DST_OFS + V4_ADDR_BYTES) begin
          tgt_w[0] = place_byte(tgt_w[0], idx - V4_DST_OFS, b);
        end
        if (ihl_b >= IPV4_MIN_HDR && idx >= ihl_b && idx < ihl_b + PORT_BYTES) begin
          place_port(idx - ihl_b, b);
        end
      end else if (ver_b[7:4] == VER_IPV6) begin
        if (idx == V6_PROTO_OFS) begin
          proto_b = b;
        end else if (idx >= V6_SRC_OFS && idx < V6_DST_OFS) begin
          src_w[(idx - V6_SRC_OFS) / V6_WORD_BYTES] =
            place_byte(src_w[(idx - V6_SRC_OFS) / V6_WORD_BYTES],
                       (idx - V6_SRC_OFS) % V6_WORD_BYTES, b);
        end else if (idx >= V6_DST_OFS && idx < IPV6_HDR_LEN) begin
          tgt_w[(idx - V6_DST_OFS) / V6_WORD_BYTES] =
            place_byte(tgt_w[(idx - V6_DST_OFS) / V6_WORD_BYTES],
                       (idx - V6_DST_OFS) % V6_WORD_BYTES, b);
        end else if (idx >= IPV6_HDR_LEN && idx < IPV6_HDR_LEN + PORT_BYTES) begin
          place_port(idx - IPV6_HDR_LEN, b);
        end
      end
    endfunction

    function void note_byte(logic [7:0] b, logic l);
      int unsigned idx;
      int unsigned len;
      int unsigned ihl_b;
      int unsigned hdr;
      family_e     fam;
      flow_key_t   k;
      idx = count;
      len = (idx >= CNT_MAX) ? CNT_MAX : idx + 1;
      capture_header(idx, b);
      count = len;
      if (!l) return;
      k   = '0;
      fam = FAM_NONE;
      hdr = 0;
      if (len >= IPV4_MIN_HDR) begin
        if (ver_b[7:4] == VER_IPV4) begin
          ihl_b = 4 * ver_b[3:0];
          if (ihl_b >= IPV4_MIN_HDR && ihl_b <= IPV4_MAX_HDR && len >= ihl_b) begin
            fam = FAM_IPV4;
            hdr = ihl_b;
          end
        end else if (ver_b[7:4] == VER_IPV6 && len >= IPV6_HDR_LEN) begin
          fam = FAM_IPV6;
          hdr = IPV6_HDR_LEN;
        end
      end
      if (fam != FAM_NONE) begin
        k.family   = fam;
        k.protocol = proto_b;
        k.src_hi   = src_w[0];
        k.tgt_hi   = tgt_w[0];
        if (fam == FAM_IPV6) begin
          k.src_lo = src_w[1];
          k.tgt_lo = tgt_w[1];
        end
        if ((proto_b == PROTO_TCP || proto_b == PROTO_UDP) && len - hdr >= PORT_BYTES) begin
          k.src_port = port_w[0];
          k.tgt_port = port_w[1];
        end
      end
      keys_due.push_back(k);
      clear_packet();
    endfunction

    function string show(flow_key_t k);
      return $sformatf("fam %0d proto %0d src %h:%h tgt %h:%h ports %0d/%0d",
                       k.family, k.protocol, k.src_hi, k.src_lo, k.tgt_hi, k.tgt_lo,
                       k.src_port, k.tgt_port);
    endfunction

    function void check_key(flow_key_t got);
      flow_key_t exp;
      bit        bad;
      if (keys_due.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected key: %s", show(got));
        return;
      end
      exp = keys_due.pop_front();
      bad = (got.family !== exp.family) || (got.protocol !== exp.protocol) ||
            (got.src_hi !== exp.src_hi) || (got.src_lo !== exp.src_lo) ||
            (got.tgt_hi !== exp.tgt_hi) || (got.tgt_lo !== exp.tgt_lo) ||
            (got.src_port !== exp.src_port) || (got.tgt_port !== exp.tgt_port);
      if (bad) begin
        failures++;
        if (failures <= 10) begin
          $display("key mismatch at %0t", $realtime);
          $display("  expected %s", show(exp));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ipfk_byte_if byte_ch ();
  ipfk_key_if  key_ch ();

  ip_flow_key_extractor_core #(
    .COUNT_WIDTH (CW)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_ch),
    .key_o  (key_ch)
  );

  key_scoreboard sb = new();
  logic [7:0]    pkt_bytes[$];
  bit            quiet;
  int            bytes_sent;
  int            packets_sent;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= l;
    @(posedge clk_i);
    while (byte_ch.ready !== 1'b1) @(posedge clk_i);
    sb.note_byte(b, l);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_packet();
    int i;
    for (i = 0; i < pkt_bytes.size(); i++) begin
      push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    end
    packets_sent++;
  endtask

  task automatic drain_keys();
    byte_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.keys_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic fill_random(input int len);
    int i;
    pkt_bytes.delete();
    for (i = 0; i < len; i++) pkt_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_packet();
    int         kind;
    int         ihl_w;
    int         len;
    int         r;
    logic [7:0] proto;
    logic [7:0] ver;
    int         proto_ofs;
    kind = $urandom_range(0, 99);
    r    = $urandom_range(0, 9);
    proto = (r < 4) ? PROTO_TCP : (r < 8) ? PROTO_UDP : 8'($urandom_range(0, 255));
    r    = $urandom_range(0, 9);
    len  = (r < 2) ? $urandom_range(0, 3) : (r < 4) ? PORT_BYTES : $urandom_range(5, 24);
    proto_ofs = V4_PROTO_OFS;
    if (kind < 40) begin
      ihl_w = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
      ver   = {VER_IPV4, 4'(ihl_w)};
      len   = 4 * ihl_w + len;
    end else if (kind < 70) begin
      ver       = {VER_IPV6, 4'($urandom_range(0, 15))};
      len       = IPV6_HDR_LEN + len;
      proto_ofs = V6_PROTO_OFS;
    end else if (kind < 80) begin
      ver = {VER_IPV4, 4'($urandom_range(0, 15))};
      len = $urandom_range(1, 70);
    end else if (kind < 88) begin
      ver       = {VER_IPV6, 4'($urandom_range(0, 15))};
      len       = $urandom_range(1, IPV6_HDR_LEN - 1);
      proto_ofs = V6_PROTO_OFS;
    end else begin
      ver = 8'($urandom_range(0, 255));
      len = $urandom_range(1, 60);
    end
    // a few packets run past the saturating counter
    if ($urandom_range(0, 99) < 3) len = $urandom_range(CNT_MAX + 1, CNT_MAX + 170);
    fill_random(len);
    pkt_bytes[0] = ver;
    if (len > proto_ofs) pkt_bytes[proto_ofs] = proto;
  endtask

  initial begin
    int i;
    rst_ni            <= 1'b0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    quiet        = 1'b1;
    bytes_sent   = 0;
    packets_sent = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // one-byte packets, all zeros and all ones
    pkt_bytes = '{8'h00};
    send_packet();
    pkt_bytes = '{8'hff};
    send_packet();
    // minimal ipv4 udp header, no room for ports
    fill_random(IPV4_MIN_HDR);
    pkt_bytes[0]            = {VER_IPV4, 4'd5};
    pkt_bytes[V4_PROTO_OFS] = PROTO_UDP;
    for (i = V4_SRC_OFS; i < IPV4_MIN_HDR; i++) pkt_bytes[i] = 8'hff;
    send_packet();
    drain_keys();

    while (bytes_sent < 1250) begin
      quiet = ($urandom_range(0, 3) == 0);
      build_packet();
      send_packet();
      if (packets_sent == 15) drain_keys();
    end
    drain_keys();
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0 && sb.keys_due.size() == 0) begin
      $display("** ip_flow_key_extractor_core: PASSED **");
    end else begin
      $display("** ip_flow_key_extractor_core: FAILED **");
    end
    $finish;
  end

  initial begin
    int on_len;
    int gap;
    key_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      on_len = $urandom_range(1, 8);
      key_ch.ready <= 1'b1;
      repeat (on_len) @(negedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        key_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    flow_key_t got;
    if (rst_ni && key_ch.valid === 1'b1 && key_ch.ready === 1'b1) begin
      got.family   = family_e'(key_ch.family_code);
      got.protocol = key_ch.protocol_number;
      got.src_hi   = key_ch.source_high;
      got.src_lo   = key_ch.source_low;
      got.tgt_hi   = key_ch.target_high;
      got.tgt_lo   = key_ch.target_low;
      got.src_port = key_ch.source_port_num;
      got.tgt_port = key_ch.target_port_num;
      sb.check_key(got);
    end
  end

  initial begin
    #8000000;
    $display("** ip_flow_key_extractor_core: FAILED **");
    $finish;
  end

endmodule
